### rtl/core/afg_pkg.sv
// Shared widths, register indexes and reset values for the fade-out and gain core.
// Used by afg_serial_mul, afg_serial_div and audio_fadeout_and_gain_core.
`default_nettype none

package afg_pkg;

  // Field widths fixed by the register map.
  localparam int GAIN_BITS      = 32;
  localparam int FADE_BITS      = 16;
  localparam int FRAME_BITS     = 32;
  localparam int CHAN_BITS      = 4;
  localparam int CHAN_POS_BITS  = 3;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOTAL_FRAMES  = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FADE_FRAMES   = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN          = 8'd3;

  // Register reset values.
  localparam logic [FRAME_BITS-1:0] TOTAL_FRAMES_RESET  = 32'd0;
  localparam logic [FADE_BITS-1:0]  FADE_FRAMES_RESET   = 16'd960;
  localparam logic [CHAN_BITS-1:0]  CHANNEL_COUNT_RESET = 4'd1;
  localparam logic [GAIN_BITS-1:0]  GAIN_RESET          = 32'd65536;

  // Largest channel count per frame.
  localparam logic [CHAN_BITS-1:0]  MAX_CHANNELS        = 4'd8;

  typedef logic [GAIN_BITS-1:0] gain_t;

endpackage

`default_nettype wire

### rtl/core/afg_serial_mul.sv
// Bit-serial shift-and-add multiplier: GAIN_BITS-wide multiplicand, B_BITS-wide multiplier.
// Depends on afg_pkg for GAIN_BITS and gain_t.
`default_nettype none

module afg_serial_mul
  import afg_pkg::*;
#(
  parameter int B_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire gain_t                       a,
  input  wire logic [B_BITS-1:0]           b,
  output logic                             done,
  output logic [GAIN_BITS+B_BITS-1:0]      product
);

  localparam int CNT_BITS = $clog2(B_BITS);

  gain_t                 a_reg;
  logic [GAIN_BITS-1:0]  hi;
  logic [B_BITS-1:0]     lo;
  logic                  busy;
  logic [CNT_BITS-1:0]   count;
  logic [GAIN_BITS:0]    sum;

  // One multiplier bit per cycle, taken from the low end of the shift register.
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, a_reg} : {(GAIN_BITS+1){1'b0}});

  assign product = {hi, lo};

  // Control: a pass over all B_BITS multiplier bits, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_BITS'(B_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then add and shift right once per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      hi    <= '0;
      lo    <= b;
    end else if (busy) begin
      hi <= sum[GAIN_BITS:1];
      lo <= {sum[0], lo[B_BITS-1:1]};
    end
  end

endmodule

`default_nettype wire

### rtl/core/afg_serial_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Expects the quotient to fit Q_BITS bits; depends on afg_pkg for FADE_BITS.
`default_nettype none

module afg_serial_div
  import afg_pkg::*;
#(
  parameter int Q_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [Q_BITS+FADE_BITS-1:0] dividend,
  input  wire logic [FADE_BITS-1:0]        divisor,
  output logic                             done,
  output logic [Q_BITS-1:0]                quotient
);

  localparam int CNT_BITS = $clog2(Q_BITS);

  logic [FADE_BITS-1:0] rem;
  logic [FADE_BITS-1:0] dvs;
  logic [Q_BITS-1:0]    quo;
  logic                 busy;
  logic [CNT_BITS-1:0]  count;
  logic [FADE_BITS:0]   partial;
  logic [FADE_BITS:0]   trial;
  logic                 fits;

  // Bring down the next dividend bit and try a subtraction.
  assign partial = {rem, quo[Q_BITS-1]};
  assign trial   = partial - {1'b0, dvs};
  assign fits    = (partial >= {1'b0, dvs});

  assign quotient = quo;

  // Control: Q_BITS steps, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_BITS'(Q_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The upper part of the dividend is already below the divisor, so only
  // the low Q_BITS bits need a step each.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[Q_BITS+FADE_BITS-1:Q_BITS];
      quo <= dividend[Q_BITS-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? trial[FADE_BITS-1:0] : partial[FADE_BITS-1:0];
      quo <= {quo[Q_BITS-2:0], fits};
    end
  end

endmodule

`default_nettype wire

### rtl/core/audio_fadeout_and_gain_core.sv
// Fade-out and gain core for interleaved signed PCM samples.
// Input channel (in_valid/in_ready) carries sample_in and track_start, one item per
// sample. Output channel (out_valid/out_ready) carries sample_out and clipped, one
// item per input item, in order. Configuration port (cfg_valid/cfg_ready, cfg_index,
// cfg_data) is always ready: index 0 total_frames, 1 fade_frames, 2 channel_count,
// 3 gain (unsigned Q16.16); other indexes are ignored.
// Sequencing: an item inside the fade window runs through the serial multiplier,
// the serial divider and the multiplier again, each one bit per cycle over
// SAMPLE_BITS bits, and then to the output register. Any other item skips the
// fade and runs through the multiplier only. One item is in work at a time;
// in_ready is high while idle, so with a ready receiver the next item is taken in
// the cycle after the previous result enters the output register. The output
// register holds a finished item while the receiver stalls, and a new input item
// is accepted meanwhile; that item waits in its last step until the output
// register is free.
// Reset (synchronous, active high) clears the frame and channel counters and
// loads the register defaults: total_frames 0, fade_frames 960, channel_count 1,
// gain 1.0.
`default_nettype none

module audio_fadeout_and_gain_core
  import afg_pkg::*;
#(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // Configuration writes
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  // Input samples
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [SAMPLE_BITS-1:0]    sample_in,
  input  wire logic                      track_start,
  // Output samples
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [SAMPLE_BITS-1:0]         sample_out,
  output logic                           clipped
);

  localparam int PROD_BITS = GAIN_BITS + SAMPLE_BITS;
  localparam int Q_BITS    = PROD_BITS - GAIN_FRAC_BITS;

  localparam logic [Q_BITS-1:0] POS_LIMIT = Q_BITS'(2**(SAMPLE_BITS-1) - 1);
  localparam logic [Q_BITS-1:0] NEG_LIMIT = Q_BITS'(2**(SAMPLE_BITS-1));
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_FSTART = 3'd2;
  localparam logic [2:0] ST_FMUL   = 3'd3;
  localparam logic [2:0] ST_FDIV   = 3'd4;
  localparam logic [2:0] ST_GSTART = 3'd5;
  localparam logic [2:0] ST_GMUL   = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  logic [2:0]               state;
  logic [2:0]               state_next;

  // Configuration registers.
  logic [FRAME_BITS-1:0]    total_frames;
  logic [FADE_BITS-1:0]     fade_frames;
  logic [CHAN_BITS-1:0]     channel_count;
  gain_t                    gain;

  // Track position of the next sample.
  logic [FRAME_BITS-1:0]    frame_position;
  logic [CHAN_POS_BITS-1:0] channel_position;

  // Per-item working registers.
  logic [FRAME_BITS-1:0]    item_frame;
  logic [SAMPLE_BITS-1:0]   smag;
  logic                     sneg;
  logic [SAMPLE_BITS-1:0]   fmag;
  logic [FADE_BITS-1:0]     fade_num;

  // Accept-time signals.
  logic                     in_fire;
  logic [FRAME_BITS-1:0]    cur_frame;
  logic [CHAN_POS_BITS-1:0] cur_chan;
  logic [CHAN_BITS-1:0]     chan_limit;
  logic [CHAN_BITS-1:0]     chan_plus;
  logic [SAMPLE_BITS-1:0]   sample_neg;

  // Fade decision signals.
  logic [FRAME_BITS:0]      frames_left;
  logic                     fade_on;
  logic                     past_end;
  logic                     in_window;

  // Shared units.
  logic                     mul_start;
  gain_t                    mul_a;
  logic [SAMPLE_BITS-1:0]   mul_b;
  logic                     mul_done;
  logic [PROD_BITS-1:0]     mul_product;
  logic                     div_start;
  logic                     div_done;
  logic [SAMPLE_BITS-1:0]   div_quotient;

  // Output saturation.
  logic [Q_BITS-1:0]        scaled;
  logic                     sat;
  logic [SAMPLE_BITS-1:0]   result;
  logic                     out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_frames  <= TOTAL_FRAMES_RESET;
      fade_frames   <= FADE_FRAMES_RESET;
      channel_count <= CHANNEL_COUNT_RESET;
      gain          <= GAIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TOTAL_FRAMES:  total_frames  <= cfg_data[FRAME_BITS-1:0];
        REG_FADE_FRAMES:   fade_frames   <= cfg_data[FADE_BITS-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CHAN_BITS-1:0];
        REG_GAIN:          gain          <= cfg_data[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Position of the accepted item; a track start puts it at channel 0 of frame 0.
  always_comb begin
    cur_frame  = track_start ? '0 : frame_position;
    cur_chan   = track_start ? '0 : channel_position;
    if (channel_count == '0) begin
      chan_limit = CHAN_BITS'(1);
    end else if (channel_count > MAX_CHANNELS) begin
      chan_limit = MAX_CHANNELS;
    end else begin
      chan_limit = channel_count;
    end
    chan_plus  = {1'b0, cur_chan} + 1'b1;
    sample_neg = '0 - sample_in;
  end

  // Frame and channel counters advance on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position   <= '0;
      channel_position <= '0;
    end else if (in_fire) begin
      if (chan_plus >= chan_limit) begin
        channel_position <= '0;
        frame_position   <= cur_frame + 1'b1;
      end else begin
        channel_position <= chan_plus[CHAN_POS_BITS-1:0];
        frame_position   <= cur_frame;
      end
    end
  end

  // Fade window: the fade runs only when the fade is not empty and the track is
  // longer than the fade, and the fade numerator equals the frames left in the track.
  always_comb begin
    frames_left = {1'b0, total_frames} - {1'b0, item_frame};
    fade_on     = (fade_frames != '0) &&
                  (total_frames > {{(FRAME_BITS-FADE_BITS){1'b0}}, fade_frames});
    past_end    = frames_left[FRAME_BITS] || (frames_left[FRAME_BITS-1:0] == '0);
    in_window   = fade_on && !past_end &&
                  (frames_left[FRAME_BITS-1:0] <=
                   {{(FRAME_BITS-FADE_BITS){1'b0}}, fade_frames});
  end

  // Operand selection for the shared multiplier.
  assign mul_start = (state == ST_FSTART) || (state == ST_GSTART);
  assign mul_a     = (state == ST_FSTART) ?
                     {{(GAIN_BITS-FADE_BITS){1'b0}}, fade_num} : gain;
  assign mul_b     = (state == ST_FSTART) ? smag : fmag;
  assign div_start = (state == ST_FMUL) && mul_done;

  afg_serial_mul #(
    .B_BITS (SAMPLE_BITS)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  afg_serial_div #(
    .Q_BITS (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_product[SAMPLE_BITS+FADE_BITS-1:0]),
    .divisor  (fade_frames),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Truncate the gain product toward zero on its magnitude, then saturate.
  always_comb begin
    scaled = mul_product[PROD_BITS-1:GAIN_FRAC_BITS];
    if (sneg) begin
      sat    = scaled > NEG_LIMIT;
      result = sat ? SAMPLE_MIN : ('0 - scaled[SAMPLE_BITS-1:0]);
    end else begin
      sat    = scaled > POS_LIMIT;
      result = sat ? SAMPLE_MAX : scaled[SAMPLE_BITS-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_fire) state_next = ST_DECIDE;
      ST_DECIDE: state_next = in_window ? ST_FSTART : ST_GSTART;
      ST_FSTART: state_next = ST_FMUL;
      ST_FMUL:   if (mul_done) state_next = ST_FDIV;
      ST_FDIV:   if (div_done) state_next = ST_GSTART;
      ST_GSTART: state_next = ST_GMUL;
      ST_GMUL:   if (mul_done) state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Per-item working registers: frame, sign and magnitude of the sample, fade numerator, faded magnitude.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_frame <= cur_frame;
      sneg       <= sample_in[SAMPLE_BITS-1];
      smag       <= sample_in[SAMPLE_BITS-1] ? sample_neg : sample_in;
    end
    if (state == ST_DECIDE) begin
      fade_num <= frames_left[FADE_BITS-1:0];
      fmag     <= (fade_on && past_end) ? '0 : smag;
    end
    if ((state == ST_FDIV) && div_done) begin
      fmag <= div_quotient;
    end
  end

  // Output register; holds its item until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && out_free) begin
      sample_out <= result;
      clipped    <= sat;
    end
  end

endmodule

`default_nettype wire

### tb/tb_audio_fadeout_and_gain_core.sv
// Self-checking testbench for audio_fadeout_and_gain_core: fade window, gain, saturation.
// Holds its own bit-exact predictor of the core and depends only on afg_pkg and the core.
`timescale 1ns / 1ps

module tb_audio_fadeout_and_gain_core;
  import afg_pkg::*;

  localparam int SAMPLE_W     = 16;
  localparam int FRAC_W       = 16;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int REPORT_MAX   = 60;
  localparam logic [31:0] UNITY_GAIN = 32'h0001_0000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clip;
  } scaled_sample_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic                       track_start = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [SAMPLE_W-1:0]        sample_out;
  logic                       clipped;

  // Predictor copy of the registers and the position counters.
  logic [FRAME_BITS-1:0]      pred_total = TOTAL_FRAMES_RESET;
  logic [FADE_BITS-1:0]       pred_fade = FADE_FRAMES_RESET;
  logic [CHAN_BITS-1:0]       pred_chans = CHANNEL_COUNT_RESET;
  gain_t                      pred_gain = GAIN_RESET;
  logic [FRAME_BITS-1:0]      frame_pos = '0;
  logic [CHAN_POS_BITS-1:0]   chan_pos = '0;

  scaled_sample_t             scaled_q[$];
  int                         mismatches = 0;
  int                         cycles = 0;
  int                         hold_req = 0;
  bit                         idle_en = 1'b1;

  audio_fadeout_and_gain_core u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_in   (sample_in),
    .track_start (track_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .clipped     (clipped)
  );

  always #5 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Fade factor for the given frame, then Q16.16 gain with truncation toward zero
  // and saturation to the sample range.
  function automatic scaled_sample_t faded_gain(input logic signed [SAMPLE_W-1:0] smp,
                                                input logic [FRAME_BITS-1:0] frame);
    longint         s;
    longint         faded;
    longint         prod;
    longint         mag;
    logic [31:0]    fade_start;
    logic [31:0]    num;
    scaled_sample_t r;
    s = smp;
    faded = s;
    if (pred_fade != 0 && pred_total > {16'd0, pred_fade}) begin
      fade_start = pred_total - pred_fade;
      if (frame >= pred_total) begin
        faded = 0;
      end else if (frame >= fade_start) begin
        num = pred_fade - (frame - fade_start);
        faded = (s * longint'(num)) / longint'(pred_fade);
      end
    end
    prod = faded * longint'(pred_gain);
    mag = (prod < 0) ? -prod : prod;
    mag = mag >> FRAC_W;
    r.clip = 1'b0;
    if (prod < 0) begin
      if (mag > 32768) begin
        r.sample = 16'sh8000;
        r.clip = 1'b1;
      end else begin
        r.sample = SAMPLE_W'(-mag);
      end
    end else if (mag > 32767) begin
      r.sample = 16'sh7FFF;
      r.clip = 1'b1;
    end else begin
      r.sample = SAMPLE_W'(mag);
    end
    return r;
  endfunction

  // Offer one item, wait for its acceptance, then record its expected result.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic start);
    int nch;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    sample_in   <= smp;
    track_start <= start;
    do @(posedge clk); while (!in_ready);
    if (start) begin
      frame_pos = '0;
      chan_pos = '0;
    end
    scaled_q.push_back(faded_gain(smp, frame_pos));
    nch = (pred_chans == 0) ? 1 : ((pred_chans > MAX_CHANNELS) ? int'(MAX_CHANNELS) : pred_chans);
    if (int'(chan_pos) + 1 >= nch) begin
      chan_pos = '0;
      frame_pos = frame_pos + 1;
    end else begin
      chan_pos = chan_pos + 1;
    end
  endtask

  // Drop the input valid and wait until every expected result has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (scaled_q.size() != 0) @(posedge clk);
  endtask

  // One register write; cfg_valid stays high so that writes can follow back to back.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TOTAL_FRAMES:  pred_total = data;
      REG_FADE_FRAMES:   pred_fade = data[FADE_BITS-1:0];
      REG_CHANNEL_COUNT: pred_chans = data[CHAN_BITS-1:0];
      REG_GAIN:          pred_gain = data;
      default: ;
    endcase
  endtask

  task automatic write_single(input logic [CFG_INDEX_BITS-1:0] idx,
                              input logic [CFG_DATA_BITS-1:0] data);
    wait_idle();
    write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] total, input logic [31:0] fade,
                           input logic [31:0] chans, input logic [31:0] gain_v);
    wait_idle();
    write_reg(REG_TOTAL_FRAMES, total);
    write_reg(REG_FADE_FRAMES, fade);
    write_reg(REG_CHANNEL_COUNT, chans);
    write_reg(REG_GAIN, gain_v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return SAMPLE_W'($urandom_range(0, 16) - 8);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return UNITY_GAIN;
      2:       return 32'hFFFF_FFFF;
      3:       return $urandom_range(0, 32'h0002_0000);
      4:       return $urandom_range(32'h0002_0000, 32'h0028_0000);
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stall bursts, plus a long hold-off when one is requested.
  initial begin : result_sink
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    scaled_sample_t want;
    if (!rst && out_valid && out_ready) begin
      if (scaled_q.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("%0t: unexpected item: expected none, actual sample_out %0d clipped %0b",
                   $time, $signed(sample_out), clipped);
        mismatches++;
      end else begin
        want = scaled_q.pop_front();
        if (sample_out !== want.sample) begin
          if (mismatches < REPORT_MAX)
            $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                     $time, want.sample, $signed(sample_out));
          mismatches++;
        end
        if (clipped !== want.clip) begin
          if (mismatches < REPORT_MAX)
            $display("%0t: clipped mismatch: expected %0b, actual %0b",
                     $time, want.clip, clipped);
          mismatches++;
        end
      end
    end
  end

  // Register defaults after reset: no fade, unity gain.
  task automatic test_reset_defaults();
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(-16'sd1, 1'b0);
  endtask

  // Saturation both ways, zero gain, and truncation of negative products toward zero.
  task automatic test_gain_extremes();
    configure(32'd0, 32'd960, 32'd1, 32'hFFFF_FFFF);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sh8000, 1'b0);
    configure(32'd0, 32'd960, 32'd1, 32'd0);
    send_sample(16'sh8000, 1'b0);
    configure(32'd0, 32'd960, 32'd1, 32'h0000_8000);
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd3, 1'b0);
  endtask

  // Frames before the fade, inside it, and past the end of the track.
  task automatic test_fade_window();
    configure(32'd4, 32'd2, 32'd1, UNITY_GAIN);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
  endtask

  // Track no longer than the fade, and a zero-length fade that runs past the end:
  // gain only.
  task automatic test_short_track();
    configure(32'd2, 32'd2, 32'd1, UNITY_GAIN);
    send_sample(16'sh7FFF, 1'b1);
    configure(32'd1, 32'd0, 32'd1, UNITY_GAIN);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
  endtask

  // Widest fade length, with the window reachable from the start of the track.
  task automatic test_long_fade();
    configure(32'd65537, 32'h0000_FFFF, 32'd1, 32'h0001_8000);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
  endtask

  // Channel count zero counts as one; lowering the count mid-frame starts a new frame.
  task automatic test_channel_count();
    configure(32'd2, 32'd1, 32'd0, UNITY_GAIN);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    configure(32'd3, 32'd2, 32'd4, UNITY_GAIN);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh8000, 1'b0);
    write_single(REG_CHANNEL_COUNT, 32'd2);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
  endtask

  // Writes to indexes outside the register map change nothing.
  task automatic test_unused_index();
    write_single(8'd4, 32'hFFFF_FFFF);
    write_single(8'hFF, 32'h0000_0001);
    send_sample(16'sh4000, 1'b0);
  endtask

  // The receiver stops for a long stretch so that the core fills and stalls its input.
  task automatic test_output_backpressure();
    int i;
    configure(32'd10, 32'd6, 32'd2, 32'h0001_4000);
    @(posedge clk);
    hold_req = 400;
    for (i = 0; i < 12; i++) send_sample(pick_sample(), i == 0);
  endtask

  // Whole tracks with random settings and content; some tracks carry stray restarts.
  task automatic test_random_tracks(input int n_items);
    int          sent;
    int          nch;
    int          n_frames;
    int          n_samples;
    int          i;
    bit          noisy;
    logic [31:0] total_v;
    logic [15:0] fade_v;
    logic [3:0]  chan_v;
    sent = 0;
    while (sent < n_items) begin
      chan_v = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
      nch = (chan_v == 0) ? 1 : ((chan_v > MAX_CHANNELS) ? int'(MAX_CHANNELS) : chan_v);
      case ($urandom_range(0, 9))
        0: begin
          fade_v = $urandom_range(65500, 65535);
          total_v = 32'(fade_v) + $urandom_range(1, 8);
        end
        1: begin
          total_v = 32'hFFFF_FFFF;
          fade_v = $urandom;
        end
        2: begin
          total_v = $urandom_range(0, 12);
          fade_v = 16'(total_v + $urandom_range(0, 3));
        end
        default: begin
          total_v = $urandom_range(2, 40);
          fade_v = $urandom_range(1, total_v - 1);
        end
      endcase
      configure(total_v, ($urandom & 32'hFFFF_0000) | 32'(fade_v),
                ($urandom & 32'hFFFF_FFF0) | 32'(chan_v), pick_gain());
      if (total_v <= 48)
        n_frames = total_v + $urandom_range(0, 3);
      else if (total_v > fade_v && total_v - fade_v <= 48)
        n_frames = total_v - fade_v + $urandom_range(1, 6);
      else
        n_frames = $urandom_range(4, 16);
      n_samples = n_frames * nch;
      if (n_samples > 120) n_samples = 120;
      if (n_samples < 1) n_samples = 1;
      if (n_samples > n_items - sent) n_samples = n_items - sent;
      noisy = ($urandom_range(0, 7) == 0);
      for (i = 0; i < n_samples; i++)
        send_sample(pick_sample(), noisy ? ($urandom_range(0, 3) == 0) : (i == 0));
      sent += n_samples;
    end
  endtask

  initial begin : run_tests
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_gain_extremes();
    test_fade_window();
    test_short_track();
    test_long_fade();
    test_channel_count();
    test_unused_index();
    test_output_backpressure();
    test_random_tracks(440);

    // Last stretch at full rate on both sides.
    wait_idle();
    idle_en = 1'b0;
    test_random_tracks(60);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/afg_pkg.sv
rtl/core/afg_serial_mul.sv
rtl/core/afg_serial_div.sv
rtl/core/audio_fadeout_and_gain_core.sv
tb/tb_audio_fadeout_and_gain_core.sv
